/* design/cartesian_to_polar_top_defines.svh */
// Assertion macros used by the checker file of the polar converter.
`ifndef CARTESIAN_TO_POLAR_TOP_DEFINES_SVH
`define CARTESIAN_TO_POLAR_TOP_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define CTP_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cartesian_to_polar check failed");

// Next-cycle implication, switched off while reset is asserted.
`define CTP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cartesian_to_polar check failed");

`endif

/* design/ctp_pkg.sv */
// Shared types, constants and elaboration-time functions of the polar converter.
`default_nettype none

package ctp_pkg;

	localparam int GUARD_BITS  = 8;
	localparam int TABLE_SIZE  = 24;
	localparam int ANGLE_W     = 19;
	localparam int ATAN_W      = 17;
	localparam int KINV_W      = 20;
	localparam int ROUND_SHIFT = KINV_W + GUARD_BITS;
	localparam int OUT_W       = 16;
	localparam int HALF_PI_Q16 = 102944;
	localparam int PI_Q13      = 25736;

	typedef struct packed {
		logic valid;
		logic origin;
	} ctp_ctrl_t;

	// Elementary angles atan(2^-i) in Q.16 radians, rounded to nearest.
	function automatic logic [ATAN_W-1:0] atan_q16(input int step);
		case (step)
			0:       return 17'd51472;
			1:       return 17'd30386;
			2:       return 17'd16055;
			3:       return 17'd8150;
			4:       return 17'd4091;
			5:       return 17'd2047;
			6:       return 17'd1024;
			7:       return 17'd512;
			8:       return 17'd256;
			9:       return 17'd128;
			10:      return 17'd64;
			11:      return 17'd32;
			12:      return 17'd16;
			13:      return 17'd8;
			14:      return 17'd4;
			15:      return 17'd2;
			16:      return 17'd1;
			default: return 17'd0;
		endcase
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] n);
		logic [63:0] rem_v;
		logic [63:0] res_v;
		logic [63:0] bit_v;
		int k;
		rem_v = n;
		res_v = '0;
		bit_v = 64'd1 << 62;
		for (k = 0; k < 32; k++) begin
			if (bit_v > rem_v) begin
				bit_v = bit_v >> 2;
			end
		end
		for (k = 0; k < 32; k++) begin
			if (bit_v != '0) begin
				if (rem_v >= res_v + bit_v) begin
					rem_v = rem_v - (res_v + bit_v);
					res_v = (res_v >> 1) + bit_v;
				end else begin
					res_v = res_v >> 1;
				end
				bit_v = bit_v >> 2;
			end
		end
		return res_v;
	endfunction

	// Reciprocal of the CORDIC gain in Q20, worked out at elaboration with a
	// bit-by-bit restoring division.
	function automatic logic [KINV_W-1:0] gain_inv_q20(input int iterations);
		logic [63:0] p;
		logic [63:0] a;
		logic [63:0] num;
		logic [63:0] quo;
		logic [63:0] rem_v;
		int i;
		p = 64'd1 << 30;
		for (i = 0; i < TABLE_SIZE; i++) begin
			if (i < iterations) begin
				p = p + (p >> (2 * i));
			end
		end
		a = isqrt64(p << 30);
		if (a == '0) begin
			a = 64'd1;
		end
		num   = (64'd1 << 50) + (a >> 1);
		quo   = '0;
		rem_v = '0;
		for (i = 63; i >= 0; i--) begin
			rem_v = {rem_v[62:0], num[i]};
			if (rem_v >= a) begin
				rem_v  = rem_v - a;
				quo[i] = 1'b1;
			end
		end
		return quo[KINV_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* design/cartesian_to_polar_top.sv */
// Pipelined CORDIC converter from a Cartesian point to magnitude and angle.
//
//   port group   dir   tdata fields (lowest bit first)
//   s_*          in    x_coord[15:0], y_coord[31:16]
//   m_*          out   magnitude[15:0], angle[31:16]
//
// One beat is taken per cycle while the output side does not stall; a result
// passes one quadrant stage, one stage per micro-rotation, a multiplier stage
// for the gain correction and the output register.
// Reset clears only the control bits (valid and origin) of the stages.
// Each stage moves on when it is empty or its successor moves, so a stall on
// the output side fills bubbles first and loses or repeats nothing.
`default_nettype none

module cartesian_to_polar_top
	import ctp_pkg::*;
#(
	parameter int ITERATIONS  = 16,
	parameter int COORD_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [2*OUT_W-1:0]   s_tdata,  // x_coord[15:0], y_coord[31:16]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [2*OUT_W-1:0]   m_tdata   // magnitude[15:0], angle[31:16]
);

	localparam int DATA_W = COORD_WIDTH + GUARD_BITS + 3;
	localparam int VAL_W  = DATA_W - GUARD_BITS;
	localparam int MAG_W  = DATA_W - 1;
	localparam int LO_W   = MAG_W / 2;
	localparam int HI_W   = MAG_W - LO_W;
	localparam int PLO_W  = LO_W + KINV_W;
	localparam int PHI_W  = HI_W + KINV_W;
	localparam int PROD_W = MAG_W + KINV_W;
	localparam int SUM_W  = (PROD_W + 1 > ROUND_SHIFT + OUT_W) ? PROD_W + 1
	                                                          : ROUND_SHIFT + OUT_W + 1;
	localparam logic [KINV_W-1:0]         KINV       = gain_inv_q20(ITERATIONS);
	localparam logic [SUM_W-1:0]          ROUND_HALF = SUM_W'(1) << (ROUND_SHIFT - 1);
	localparam logic signed [ANGLE_W-1:0] HALF_PI    = ANGLE_W'(HALF_PI_Q16);
	localparam logic signed [ANGLE_W-1:0] PI_LIM     = ANGLE_W'(PI_Q13);

	logic [OUT_W-1:0]          x_raw;
	logic [OUT_W-1:0]          y_raw;
	logic signed [DATA_W-1:0]  x_val;
	logic signed [DATA_W-1:0]  y_val;
	logic signed [DATA_W-1:0]  x_rot;
	logic signed [DATA_W-1:0]  y_rot;
	logic signed [ANGLE_W-1:0] z_rot;
	ctp_ctrl_t                 ctrl_in;

	ctp_ctrl_t                 ctrl_s1;
	logic signed [DATA_W-1:0]  x_s1;
	logic signed [DATA_W-1:0]  y_s1;
	logic signed [ANGLE_W-1:0] z_s1;

	ctp_ctrl_t                 ctrl_pl [ITERATIONS+1];
	logic signed [DATA_W-1:0]  x_pl    [ITERATIONS+1];
	logic signed [DATA_W-1:0]  y_pl    [ITERATIONS+1];
	logic signed [ANGLE_W-1:0] z_pl    [ITERATIONS+1];
	logic                      rdy     [ITERATIONS+1];

	logic [MAG_W-1:0]          xf;
	logic signed [ANGLE_W-1:0] z_rnd;
	logic signed [ANGLE_W-1:0] z_clamp;
	ctp_ctrl_t                 ctrl_sm;
	logic [PLO_W-1:0]          prod_lo_sm;
	logic [PHI_W-1:0]          prod_hi_sm;
	logic [OUT_W-1:0]          ang_sm;
	logic                      rdy_sm;

	logic [SUM_W-1:0]          mag_sum;
	logic [OUT_W-1:0]          mag_next;
	ctp_ctrl_t                 ctrl_so;
	logic [OUT_W-1:0]          mag_so;
	logic [OUT_W-1:0]          ang_so;
	logic                      rdy_so;

	assign x_raw = s_tdata[OUT_W-1:0];
	assign y_raw = s_tdata[2*OUT_W-1:OUT_W];

	// Coordinates are taken as COORD_WIDTH-bit two's complement (16-bit fields zero-extended
	// when COORD_WIDTH exceeds OUT_W) and scaled by the guard bits.
	if (COORD_WIDTH <= OUT_W) begin : g_narrow
		assign x_val = {{(VAL_W-COORD_WIDTH){x_raw[COORD_WIDTH-1]}},
		                x_raw[COORD_WIDTH-1:0], {GUARD_BITS{1'b0}}};
		assign y_val = {{(VAL_W-COORD_WIDTH){y_raw[COORD_WIDTH-1]}},
		                y_raw[COORD_WIDTH-1:0], {GUARD_BITS{1'b0}}};
	end else begin : g_wide
		assign x_val = {{(VAL_W-OUT_W){1'b0}}, x_raw, {GUARD_BITS{1'b0}}};
		assign y_val = {{(VAL_W-OUT_W){1'b0}}, y_raw, {GUARD_BITS{1'b0}}};
	end

	// Points in the left half plane are turned by a quarter turn first.
	always_comb begin
		if (x_val[DATA_W-1]) begin
			if (!y_val[DATA_W-1]) begin
				x_rot = y_val;
				y_rot = -x_val;
				z_rot = HALF_PI;
			end else begin
				x_rot = -y_val;
				y_rot = x_val;
				z_rot = -HALF_PI;
			end
		end else begin
			x_rot = x_val;
			y_rot = y_val;
			z_rot = '0;
		end
		ctrl_in.valid  = s_tvalid;
		ctrl_in.origin = (x_val == '0) && (y_val == '0);
	end

	assign s_tready = rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (rdy[0]) begin
			ctrl_s1 <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			x_s1 <= x_rot;
			y_s1 <= y_rot;
			z_s1 <= z_rot;
		end
	end

	assign ctrl_pl[0] = ctrl_s1;
	assign x_pl[0]    = x_s1;
	assign y_pl[0]    = y_s1;
	assign z_pl[0]    = z_s1;

	for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
		assign rdy[k] = !ctrl_pl[k].valid || rdy[k+1];

		ctp_stage #(
			.DATA_W (DATA_W),
			.STEP   (k)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.load     (rdy[k+1]),
			.in_ctrl  (ctrl_pl[k]),
			.in_x     (x_pl[k]),
			.in_y     (y_pl[k]),
			.in_z     (z_pl[k]),
			.out_ctrl (ctrl_pl[k+1]),
			.out_x    (x_pl[k+1]),
			.out_y    (y_pl[k+1]),
			.out_z    (z_pl[k+1])
		);
	end

	assign rdy[ITERATIONS] = !ctrl_pl[ITERATIONS].valid || rdy_sm;
	assign rdy_sm          = !ctrl_sm.valid || rdy_so;
	assign rdy_so          = !ctrl_so.valid || m_tready;

	// Gain correction is split in two half-width products; the angle is
	// rounded from Q.16 to Q.13 and clamped to the range of pi.
	assign xf = x_pl[ITERATIONS][DATA_W-1] ? '0 : x_pl[ITERATIONS][MAG_W-1:0];

	always_comb begin
		z_rnd = (z_pl[ITERATIONS] + ANGLE_W'(4)) >>> 3;
		if (z_rnd > PI_LIM) begin
			z_clamp = PI_LIM;
		end else if (z_rnd < -PI_LIM) begin
			z_clamp = -PI_LIM;
		end else begin
			z_clamp = z_rnd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_sm <= '0;
		end else if (rdy_sm) begin
			ctrl_sm <= ctrl_pl[ITERATIONS];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_sm) begin
			prod_lo_sm <= {{KINV_W{1'b0}}, xf[LO_W-1:0]} * {{LO_W{1'b0}}, KINV};
			prod_hi_sm <= {{KINV_W{1'b0}}, xf[MAG_W-1:LO_W]} * {{HI_W{1'b0}}, KINV};
			ang_sm     <= z_clamp[OUT_W-1:0];
		end
	end

	always_comb begin
		mag_sum = (SUM_W'(prod_hi_sm) << LO_W) + SUM_W'(prod_lo_sm) + ROUND_HALF;
		if (|mag_sum[SUM_W-1:ROUND_SHIFT+OUT_W]) begin
			mag_next = '1;
		end else begin
			mag_next = mag_sum[ROUND_SHIFT+OUT_W-1:ROUND_SHIFT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_so <= '0;
		end else if (rdy_so) begin
			ctrl_so <= ctrl_sm;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_so) begin
			if (ctrl_sm.origin) begin
				mag_so <= '0;
				ang_so <= '0;
			end else begin
				mag_so <= mag_next;
				ang_so <= ang_sm;
			end
		end
	end

	assign m_tvalid = ctrl_so.valid;
	assign m_tdata  = {ang_so, mag_so};

endmodule

`default_nettype wire

/* design/ctp_stage.sv */
// One vectoring micro-rotation of the CORDIC pipeline with its stage register.
`default_nettype none

module ctp_stage
	import ctp_pkg::*;
#(
	parameter int DATA_W = 27,
	parameter int STEP   = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  ctp_ctrl_t                 in_ctrl,
	input  logic signed [DATA_W-1:0]  in_x,
	input  logic signed [DATA_W-1:0]  in_y,
	input  logic signed [ANGLE_W-1:0] in_z,
	output ctp_ctrl_t                 out_ctrl,
	output logic signed [DATA_W-1:0]  out_x,
	output logic signed [DATA_W-1:0]  out_y,
	output logic signed [ANGLE_W-1:0] out_z
);

	localparam logic signed [ANGLE_W-1:0] STEP_ANGLE = ANGLE_W'(atan_q16(STEP));

	logic signed [DATA_W-1:0]  xs;
	logic signed [DATA_W-1:0]  ys;
	logic signed [DATA_W-1:0]  x_next;
	logic signed [DATA_W-1:0]  y_next;
	logic signed [ANGLE_W-1:0] z_next;
	ctp_ctrl_t                 ctrl_q;
	logic signed [DATA_W-1:0]  x_q;
	logic signed [DATA_W-1:0]  y_q;
	logic signed [ANGLE_W-1:0] z_q;

	assign xs = in_x >>> STEP;
	assign ys = in_y >>> STEP;

	// Rotate towards the x axis: the sign of y picks the direction.
	always_comb begin
		if (!in_y[DATA_W-1]) begin
			x_next = in_x + ys;
			y_next = in_y - xs;
			z_next = in_z + STEP_ANGLE;
		end else begin
			x_next = in_x - ys;
			y_next = in_y + xs;
			z_next = in_z - STEP_ANGLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else if (load) begin
			ctrl_q <= in_ctrl;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= x_next;
			y_q <= y_next;
			z_q <= z_next;
		end
	end

	assign out_ctrl = ctrl_q;
	assign out_x    = x_q;
	assign out_y    = y_q;
	assign out_z    = z_q;

endmodule

`default_nettype wire

/* design/ctp_checker.sv */
// Port-level checks of the polar converter, bound to its top level.
`default_nettype none

`include "cartesian_to_polar_top_defines.svh"

module ctp_checker
	import ctp_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [31:0] s_tdata,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [31:0] m_tdata
);

	logic signed [15:0] out_angle;

	assign out_angle = m_tdata[31:16];

	// A result that is not taken stays put.
	`CTP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// With the output register empty no stage can be blocked.
	`CTP_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready)

	// The angle never leaves the range of minus pi to pi.
	`CTP_ASSERT_IMPL(a_angle_range, clk, arst_n, m_tvalid, (out_angle <= PI_Q13) && (out_angle >= -PI_Q13))

	// A beat offered at the input and not yet taken is held by the sender.
	`CTP_ASSERT_NEXT(a_in_hold, clk, arst_n, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata))

endmodule

bind cartesian_to_polar_top ctp_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
